// ===== rtl/trimod_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package trimod_pkg;

    // Width of the modulus, the operands and the result.
    localparam int WORD_BITS = 31;
    // Bit counter width; it counts 0 .. WORD_BITS-1.
    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int CFG_IDX_W = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS = 2'd0;
    localparam t_cfg_idx CFG_OFFSET  = 2'd1;
    localparam t_cfg_idx CFG_COEFF   = 2'd2;
    localparam t_cfg_idx CFG_DEGREE  = 2'd3;

    localparam t_word WORD_ONE   = t_word'(1);
    localparam t_word WORD_TWO   = t_word'(2);
    localparam t_cnt  CNT_LAST   = t_cnt'(WORD_BITS - 1);

    // One step of an MSB-first modular multiply: (2*acc + b*u) mod m.
    // With acc < m and u < m the sum stays below 3m, so at most 2m is taken off.
    function automatic t_word mod_step(t_word acc, t_word u, logic b, t_word m);
        logic [WORD_BITS+2:0] t;
        logic [WORD_BITS+2:0] d1;
        logic [WORD_BITS+2:0] d2;
        t  = {2'b00, acc, 1'b0} + {3'b000, (b ? u : t_word'(0))};
        d1 = t - {3'b000, m};
        d2 = t - {2'b00, m, 1'b0};
        if (!d2[WORD_BITS+2]) begin
            mod_step = d2[WORD_BITS-1:0];
        end else if (!d1[WORD_BITS+2]) begin
            mod_step = d1[WORD_BITS-1:0];
        end else begin
            mod_step = t[WORD_BITS-1:0];
        end
    endfunction

    // (u + v) mod m for u, v < m.
    function automatic t_word add_mod(t_word u, t_word v, t_word m);
        logic [WORD_BITS:0]   s;
        logic [WORD_BITS+1:0] d;
        s = {1'b0, u} + {1'b0, v};
        d = {1'b0, s} - {2'b00, m};
        if (!d[WORD_BITS+1]) begin
            add_mod = d[WORD_BITS-1:0];
        end else begin
            add_mod = s[WORD_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/trinomial_eval_mod_prime.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted item runs through the reduction, power, multiply and add states into
// the output register, or goes straight there when the modulus is below two. One item
// is in work at a time: a new item is taken once the last is in the output register.
// The bit-serial multiplier works one multiplier bit per cycle, in W exponent rounds.
// Reset is synchronous and active low: it clears the control state and the output
// valid and loads the registers with modulus 2, constant 0, coefficient 0 and degree 0.

module trinomial_eval_mod_prime (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // Input channel.
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire trimod_pkg::t_word   i_x_value,
    // Output channel.
    output logic                     o_valid,
    input  wire                      i_stall,
    output trimod_pkg::t_word        o_fx_value,
    // Configuration write channel.
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire trimod_pkg::t_cfg_idx i_cfg_index,
    input  wire trimod_pkg::t_word   i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
    localparam logic [2:0] ST_RED1 = 3'd1;  // reduce x and c mod p
    localparam logic [2:0] ST_RED2 = 3'd2;  // reduce a mod p
    localparam logic [2:0] ST_POW  = 3'd3;  // square-and-multiply rounds
    localparam logic [2:0] ST_MULC = 3'd4;  // c * x^d
    localparam logic [2:0] ST_ADD1 = 3'd5;  // a + x
    localparam logic [2:0] ST_ADD2 = 3'd6;  // + c * x^d
    localparam logic [2:0] ST_FIN  = 3'd7;  // hand the result to the output register

    // Configuration registers.
    trimod_pkg::t_word r_modulus;
    trimod_pkg::t_word r_offset;
    trimod_pkg::t_word r_coeff;
    trimod_pkg::t_word r_degree;

    // Control state.
    logic [2:0]        r_state;
    trimod_pkg::t_cnt  r_bit_cnt;
    trimod_pkg::t_cnt  r_exp_cnt;
    logic              r_out_valid;

    // Two multiplier lanes. Each holds a multiplicand, a multiplier that shifts out
    // MSB first, and an accumulator that is kept reduced below the modulus.
    trimod_pkg::t_word r_mul_a;
    trimod_pkg::t_word r_q_a;
    trimod_pkg::t_word r_acc_a;
    trimod_pkg::t_word r_mul_b;
    trimod_pkg::t_word r_q_b;
    trimod_pkg::t_word r_acc_b;

    // Reduced operands, the remaining exponent and the running sum.
    trimod_pkg::t_word r_xr;
    trimod_pkg::t_word r_cr;
    trimod_pkg::t_word r_ar;
    trimod_pkg::t_word r_exp;
    trimod_pkg::t_word r_sum;
    trimod_pkg::t_word r_fx;

    trimod_pkg::t_word step_a;
    trimod_pkg::t_word step_b;
    trimod_pkg::t_word q_a_shift;
    trimod_pkg::t_word q_b_shift;
    trimod_pkg::t_word pow_new;
    logic              bit_last;
    logic              exp_last;
    logic              out_load;
    logic              small_mod;

    // A lane with multiplicand 1 turns its multiplier word into that word mod p,
    // which is how the operands are reduced. In the power rounds lane A forms r*b
    // and lane B forms b*b from the same multiplier bits of b.
    assign step_a    = trimod_pkg::mod_step(r_acc_a, r_mul_a, r_q_a[trimod_pkg::WORD_BITS-1],
                                            r_modulus);
    assign step_b    = trimod_pkg::mod_step(r_acc_b, r_mul_b, r_q_b[trimod_pkg::WORD_BITS-1],
                                            r_modulus);
    assign q_a_shift = {r_q_a[trimod_pkg::WORD_BITS-2:0], 1'b0};
    assign q_b_shift = {r_q_b[trimod_pkg::WORD_BITS-2:0], 1'b0};
    // The running power takes the product only where the exponent bit is set.
    assign pow_new   = r_exp[0] ? step_a : r_mul_a;
    assign bit_last  = (r_bit_cnt == trimod_pkg::CNT_LAST);
    assign exp_last  = (r_exp_cnt == trimod_pkg::CNT_LAST);
    assign small_mod = (r_modulus < trimod_pkg::WORD_TWO);
    // The result moves into the output register once that register is free.
    assign out_load  = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_fx_value  = r_fx;
    assign o_cfg_ready = 1'b1;

    // Control and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit_cnt   <= '0;
            r_exp_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_modulus   <= trimod_pkg::WORD_TWO;
            r_offset    <= '0;
            r_coeff     <= '0;
            r_degree    <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    trimod_pkg::CFG_MODULUS: r_modulus <= i_cfg_data;
                    trimod_pkg::CFG_OFFSET:  r_offset  <= i_cfg_data;
                    trimod_pkg::CFG_COEFF:   r_coeff   <= i_cfg_data;
                    trimod_pkg::CFG_DEGREE:  r_degree  <= i_cfg_data;
                endcase
            end

            // The output register fills from the last state and empties when its
            // item is taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_bit_cnt <= '0;
                        r_exp_cnt <= '0;
                        // A modulus of zero or one maps every item to zero.
                        r_state   <= small_mod ? ST_FIN : ST_RED1;
                    end
                end
                ST_RED1, ST_RED2, ST_MULC: begin
                    if (bit_last) begin
                        r_bit_cnt <= '0;
                        unique case (r_state)
                            ST_RED1: r_state <= ST_RED2;
                            ST_RED2: r_state <= ST_POW;
                            default: r_state <= ST_ADD1;
                        endcase
                    end else begin
                        r_bit_cnt <= r_bit_cnt + trimod_pkg::t_cnt'(1);
                    end
                end
                ST_POW: begin
                    if (bit_last) begin
                        r_bit_cnt <= '0;
                        if (exp_last) begin
                            r_exp_cnt <= '0;
                            r_state   <= ST_MULC;
                        end else begin
                            r_exp_cnt <= r_exp_cnt + trimod_pkg::t_cnt'(1);
                        end
                    end else begin
                        r_bit_cnt <= r_bit_cnt + trimod_pkg::t_cnt'(1);
                    end
                end
                ST_ADD1: r_state <= ST_ADD2;
                ST_ADD2: r_state <= ST_FIN;
                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Datapath; no reset needed.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_q_a   <= i_x_value;
                    r_mul_a <= trimod_pkg::WORD_ONE;
                    r_acc_a <= '0;
                    r_q_b   <= r_coeff;
                    r_mul_b <= trimod_pkg::WORD_ONE;
                    r_acc_b <= '0;
                    r_sum   <= '0;
                end
            end
            ST_RED1, ST_RED2, ST_POW, ST_MULC: begin
                if (!bit_last) begin
                    r_acc_a <= step_a;
                    r_q_a   <= q_a_shift;
                    r_acc_b <= step_b;
                    r_q_b   <= q_b_shift;
                end else begin
                    unique case (r_state)
                        ST_RED1: begin
                            r_xr    <= step_a;
                            r_cr    <= step_b;
                            r_q_a   <= r_offset;
                            r_mul_a <= trimod_pkg::WORD_ONE;
                            r_acc_a <= '0;
                            r_acc_b <= step_b;
                            r_q_b   <= q_b_shift;
                        end
                        ST_RED2: begin
                            // Start with r = 1 and b = x mod p.
                            r_ar    <= step_a;
                            r_mul_a <= trimod_pkg::WORD_ONE;
                            r_q_a   <= r_xr;
                            r_acc_a <= '0;
                            r_mul_b <= r_xr;
                            r_q_b   <= r_xr;
                            r_acc_b <= '0;
                            r_exp   <= r_degree;
                        end
                        ST_POW: begin
                            r_acc_a <= '0;
                            r_acc_b <= '0;
                            r_exp   <= r_exp >> 1;
                            if (exp_last) begin
                                // Last round: set up c * x^d in lane A.
                                r_q_a   <= pow_new;
                                r_mul_a <= r_cr;
                                r_q_b   <= q_b_shift;
                            end else begin
                                r_mul_a <= pow_new;
                                r_q_a   <= step_b;
                                r_mul_b <= step_b;
                                r_q_b   <= step_b;
                            end
                        end
                        default: begin
                            // c * x^d is left in the lane A accumulator.
                            r_acc_a <= step_a;
                            r_q_a   <= q_a_shift;
                            r_acc_b <= step_b;
                            r_q_b   <= q_b_shift;
                        end
                    endcase
                end
            end
            ST_ADD1: r_sum <= trimod_pkg::add_mod(r_ar, r_xr, r_modulus);
            ST_ADD2: r_sum <= trimod_pkg::add_mod(r_sum, r_acc_a, r_modulus);
            ST_FIN: begin
                if (out_load) begin
                    r_fx <= r_sum;
                end
            end
        endcase
    end

    // An accepted item with a usable modulus always starts with the reduction pass.
    a_start_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !small_mod) |=> (r_state == ST_RED1))
        else $error("accepted item did not start the reduction pass");

    // Both lane accumulators stay reduced while the lanes run.
    a_lane_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RED1 || r_state == ST_RED2 || r_state == ST_POW
         || r_state == ST_MULC) |-> (r_acc_a < r_modulus && r_acc_b < r_modulus))
        else $error("lane accumulator not below the modulus");

    // A result loaded for a usable modulus lies below that modulus.
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !small_mod) |=> (o_valid && o_fx_value < r_modulus))
        else $error("result not reduced below the modulus");

endmodule

`default_nettype wire
